[hdl/range_bit_set_clear_flip_count_unit_macros.svh]
// Assertion macros shared by the checker of the range bit unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RANGE_BIT_SET_CLEAR_FLIP_COUNT_UNIT_MACROS_SVH
`define RANGE_BIT_SET_CLEAR_FLIP_COUNT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RBSCF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBSCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rbscf_pkg.sv]
// Types, constants and helpers for the range bit set/clear/invert/count unit.
// No dependencies; imported by the cell and the top level.
package rbscf_pkg;

    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int WORD_BITS = 32;
    localparam int OFF_W     = 5;
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    // Action codes on the input channel
    localparam logic [2:0] ACT_LOAD   = 3'd0;
    localparam logic [2:0] ACT_SET    = 3'd1;
    localparam logic [2:0] ACT_CLEAR  = 3'd2;
    localparam logic [2:0] ACT_INVERT = 3'd3;
    localparam logic [2:0] ACT_COUNT  = 3'd4;

    // Normalized operation carried down the cell chain
    typedef enum logic [2:0] {
        OP_NOP,
        OP_SET,
        OP_CLEAR,
        OP_INVERT,
        OP_COUNT
    } op_t;

    typedef struct packed {
        logic             valid;
        op_t              op;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [CNT_W-1:0] count;
    } tok_t;

    function automatic logic [OFF_W:0] popcount(input logic [WORD_BITS-1:0] w);
        logic [OFF_W:0] sum;
        sum = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            sum = sum + {{OFF_W{1'b0}}, w[i]};
        end
        return sum;
    endfunction

endpackage

[hdl/range_bit_set_clear_flip_count_unit.sv]
// Range bit set/clear/invert/count unit: top level with the cell chain and
// the result register. Uses rbscf_pkg and rbscf_cell.
//
// The bit store lives in a chain of (NUM_BITS+31)/32 cells, one 32-bit word
// each, cleared by reset. An accepted transaction walks the chain one cell
// per cycle while the chain is not frozen, and in_ready stays low from the
// accept until the transaction leaves the last cell; the unit holds one
// transaction at a time. A count result is offered in the output register
// as the transaction leaves the last cell, and may wait there while the next
// transaction is accepted; a later count that reaches the end of the chain
// while that result still waits freezes the chain until the result is taken.
// Loads beyond the store and action codes 5-7 change nothing; range ends
// beyond the store are clipped.
module range_bit_set_clear_flip_count_unit
    import rbscf_pkg::*;
#(
    parameter int NUM_BITS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       action,
    input  logic [IDX_W-1:0] first_index,
    input  logic [IDX_W-1:0] last_index,
    input  logic             bit_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CNT_W-1:0] ones_count
);

    localparam int WORD_COUNT = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;

    tok_t             chain [0:WORD_COUNT];
    tok_t             head;
    tok_t             tail;
    logic             advance;
    logic             accept;
    logic             take_result;
    logic             busy_reg, busy_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] hi_clip;

    assign accept = in_valid && in_ready;
    assign tail   = chain[WORD_COUNT];

    always_comb
    begin
        hi_clip = (int'(last_index) >= NUM_BITS) ? IDX_W'(NUM_BITS - 1) : last_index;
        head.valid = accept;
        head.lo    = first_index;
        head.hi    = hi_clip;
        head.count = '0;
        head.op    = OP_NOP;
        unique case (action)
            ACT_LOAD:
            begin
                head.hi = first_index;
                if (int'(first_index) < NUM_BITS)
                begin
                    head.op = bit_value ? OP_SET : OP_CLEAR;
                end
            end
            ACT_SET:    head.op = OP_SET;
            ACT_CLEAR:  head.op = OP_CLEAR;
            ACT_INVERT: head.op = OP_INVERT;
            ACT_COUNT:  head.op = OP_COUNT;
            default:    head.op = OP_NOP;
        endcase
    end

    assign chain[0] = head;

    for (genvar k = 0; k < WORD_COUNT; k++)
    begin : g_cell
        rbscf_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    // Freeze the chain only when a count result finds the output still full
    assign advance = !(tail.valid && (tail.op == OP_COUNT)
                       && out_valid_reg && !out_ready);
    assign take_result = tail.valid && (tail.op == OP_COUNT) && advance;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.valid && advance)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        if (take_result)
        begin
            out_valid_next = 1'b1;
            count_next     = tail.count;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign in_ready   = !busy_reg;
    assign out_valid  = out_valid_reg;
    assign ones_count = count_reg;

endmodule

[hdl/rbscf_cell.sv]
// One cell of the chain: holds a 32-bit word of the bit store, applies the
// passing transaction to it and hands the transaction on. Uses rbscf_pkg.
module rbscf_cell
    import rbscf_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  tok_t tok_in,
    output tok_t tok_out
);

    logic [WORD_BITS-1:0] word_reg, word_next;
    tok_t                 tok_reg, tok_next;
    logic [WORD_BITS-1:0] mask;
    logic [OFF_W-1:0]     lo_off, hi_off;
    logic [IDX_W-OFF_W-1:0] lo_word, hi_word;
    logic                 covered;

    assign lo_word = tok_in.lo[IDX_W-1:OFF_W];
    assign hi_word = tok_in.hi[IDX_W-1:OFF_W];

    // Range mask restricted to this word
    always_comb
    begin
        lo_off  = (int'(lo_word) < CELL_INDEX) ? '0 : tok_in.lo[OFF_W-1:0];
        hi_off  = (int'(hi_word) > CELL_INDEX) ? '1 : tok_in.hi[OFF_W-1:0];
        covered = (int'(lo_word) <= CELL_INDEX) && (int'(hi_word) >= CELL_INDEX);
        if (covered)
        begin
            mask = (ONES << lo_off) & (ONES >> (OFF_W'(WORD_BITS - 1) - hi_off));
        end
        else
        begin
            mask = '0;
        end
    end

    always_comb
    begin
        word_next = word_reg;
        tok_next  = tok_in;
        if (tok_in.valid)
        begin
            unique case (tok_in.op)
                OP_SET:    word_next = word_reg | mask;
                OP_CLEAR:  word_next = word_reg & ~mask;
                OP_INVERT: word_next = word_reg ^ mask;
                OP_COUNT:
                begin
                    tok_next.count = tok_in.count
                                   + CNT_W'(popcount(word_reg & mask));
                end
                OP_NOP:    word_next = word_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            tok_reg  <= '0;
        end
        else if (advance)
        begin
            word_reg <= word_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[hdl/rbscf_checker.sv]
// Port-level checker for the range bit unit, bound to the top level.
// Uses rbscf_pkg and the assertion macros header.
`include "range_bit_set_clear_flip_count_unit_macros.svh"

module rbscf_checker
    import rbscf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic [2:0]       action,
    input logic [IDX_W-1:0] first_index,
    input logic [IDX_W-1:0] last_index,
    input logic             bit_value,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CNT_W-1:0] ones_count
);

    logic in_accept;
    logic out_stall;

    assign in_accept = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // one transaction in the chain at a time
    `RBSCF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_accept, !in_ready, "input accepted while busy")
    // a waiting result holds
    `RBSCF_ASSERT_NEXT(a_result_holds, clk, rst_n, out_stall, out_valid && $stable(ones_count), "stalled result changed")
    // count never exceeds the widest range
    `RBSCF_ASSERT_IMPLY(a_count_range, clk, rst_n, out_valid, ones_count <= 11'd1024, "ones_count out of range")
    // a reversed count range sees an empty store slice; any result appears only after acceptance
    `RBSCF_ASSERT_NEXT(a_no_early_result, clk, rst_n, !out_valid && in_ready && !in_valid, !out_valid, "result without transaction")

endmodule

bind range_bit_set_clear_flip_count_unit rbscf_checker u_rbscf_checker (.*);

[dv/range_bit_set_clear_flip_count_unit_checker.sv]
// Checker for the range bit set/clear/invert/count unit: keeps its own image
// of the bit store, predicts every count and compares it with the output.
// Depends on rbscf_pkg.
module range_bit_set_clear_flip_count_unit_checker
    import rbscf_pkg::*;
#(
    parameter int NUM_BITS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [2:0]       action,
    input  logic [IDX_W-1:0] first_index,
    input  logic [IDX_W-1:0] last_index,
    input  logic             bit_value,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [CNT_W-1:0] ones_count,
    output int               error_count,
    output int               pending_count
);

    logic [NUM_BITS-1:0] bit_image;
    logic [CNT_W-1:0]    count_queue[$];

    // Applies one transaction to the bit image; a count pushes its expected value.
    task automatic apply_action(input logic [2:0] act, input logic [IDX_W-1:0] lo,
                                input logic [IDX_W-1:0] hi, input logic val);
        int               top_idx;
        logic [CNT_W-1:0] total;
        total = '0;
        if (act == ACT_LOAD)
        begin
            if (lo < NUM_BITS)
                bit_image[lo] = val;
        end
        else if (act <= ACT_COUNT)
        begin
            top_idx = (hi >= NUM_BITS) ? NUM_BITS - 1 : int'(hi);
            for (int n = lo; n <= top_idx; n++)
            begin
                case (act)
                    ACT_SET:    bit_image[n] = 1'b1;
                    ACT_CLEAR:  bit_image[n] = 1'b0;
                    ACT_INVERT: bit_image[n] = ~bit_image[n];
                    default:    total = total + bit_image[n];
                endcase
            end
            if (act == ACT_COUNT)
                count_queue.push_back(total);
        end
        // codes above ACT_COUNT leave the store alone
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [CNT_W-1:0] want;
        if (!rst_n)
        begin
            bit_image = '0;
            count_queue.delete();
            error_count = 0;
            pending_count = 0;
        end
        else
        begin
            // compare before predicting: a result never belongs to this cycle's input
            if (out_valid && out_ready)
            begin
                if (count_queue.size() == 0)
                begin
                    $display("%0t: unexpected ones_count: expected none, actual %0d",
                             $time, ones_count);
                    error_count++;
                end
                else
                begin
                    want = count_queue.pop_front();
                    if (ones_count !== want)
                    begin
                        $display("%0t: ones_count mismatch: expected %0d, actual %0d",
                                 $time, want, ones_count);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                apply_action(action, first_index, last_index, bit_value);
            pending_count = count_queue.size();
        end
    end

endmodule

[dv/range_bit_set_clear_flip_count_unit_test.sv]
// Testbench top for the range bit set/clear/invert/count unit: clock, reset,
// directed and random transactions, receiver stalls and the verdict.
// Depends on rbscf_pkg, the unit and range_bit_set_clear_flip_count_unit_checker.
module range_bit_set_clear_flip_count_unit_test;
    import rbscf_pkg::*;

    localparam int STORE_BITS   = 1024;
    localparam int RANDOM_ITEMS = 1760;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_IDX      = 1023;

    // codes the unit must ignore
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [2:0]       action;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
    logic             bit_value;
    logic             out_valid;
    logic             out_ready;
    logic [CNT_W-1:0] ones_count;
    int               error_count;
    int               pending_count;
    bit               calm;
    bit               hold_req;

    range_bit_set_clear_flip_count_unit #(.NUM_BITS(STORE_BITS)) u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .first_index (first_index),
        .last_index  (last_index),
        .bit_value   (bit_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ones_count  (ones_count)
    );

    range_bit_set_clear_flip_count_unit_checker #(.NUM_BITS(STORE_BITS)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .first_index   (first_index),
        .last_index    (last_index),
        .bit_value     (bit_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ones_count    (ones_count),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("range_bit_set_clear_flip_count_unit_test NOT OK");
        $finish;
    end

    // Offers one transaction at a falling edge and holds it until accepted.
    task automatic send_op(input logic [2:0] act, input int lo, input int hi,
                           input logic val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action      = act;
        first_index = IDX_W'(lo);
        last_index  = IDX_W'(hi);
        bit_value   = val;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random range, biased toward ordered, short and word-aligned ranges.
    task automatic pick_range(output int lo, output int hi);
        int pick;
        int tmp;
        pick = $urandom_range(0, 99);
        lo = $urandom_range(0, MAX_IDX);
        hi = $urandom_range(0, MAX_IDX);
        if (pick < 45)
        begin
            if (lo > hi)
            begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
        end
        else if (pick < 75)
        begin
            hi = lo + $urandom_range(0, 40);
            if (hi > MAX_IDX)
                hi = MAX_IDX;
        end
        else if (pick < 90)
        begin
            lo = 32 * $urandom_range(0, 31) + ($urandom_range(0, 1) ? 0 : 31);
            hi = 32 * $urandom_range(0, 31) + ($urandom_range(0, 1) ? 0 : 31);
            if (lo > hi)
            begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
        end
        else if (pick < 95)
        begin
            lo = 0;
            hi = MAX_IDX;
        end
        // else leave it unordered, often reversed
    endtask

    task automatic send_random(output bit useful);
        int         pick;
        int         lo;
        int         hi;
        logic [2:0] act;
        pick = $urandom_range(0, 99);
        useful = 1'b1;
        if (pick < 20)
            act = ACT_LOAD;
        else if (pick < 35)
            act = ACT_SET;
        else if (pick < 50)
            act = ACT_CLEAR;
        else if (pick < 65)
            act = ACT_INVERT;
        else if (pick < 97)
            act = ACT_COUNT;
        else
        begin
            useful = 1'b0;
            case ($urandom_range(0, 2))
                0:       act = ACT_RSVD5;
                1:       act = ACT_RSVD6;
                default: act = ACT_RSVD7;
            endcase
        end
        pick_range(lo, hi);
        send_op(act, lo, hi, 1'($urandom_range(0, 1)));
    endtask

    // Receiver: random stalls per result, plus one long hold on request.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int sent;
        int lo;
        int hi;
        bit useful;
        bit hold_done;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_LOAD;
        first_index = '0;
        last_index  = '0;
        bit_value   = 1'b0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: full ranges, max count, reversed ranges, end bits, unused codes
        send_op(ACT_COUNT, 0, MAX_IDX, 1'b0);
        send_op(ACT_SET, 0, MAX_IDX, 1'b0);
        send_op(ACT_COUNT, 0, MAX_IDX, 1'b1);
        send_op(ACT_CLEAR, 5, 9, 1'b0);
        send_op(ACT_COUNT, 0, MAX_IDX, 1'b0);
        send_op(ACT_COUNT, 5, 9, 1'b0);
        send_op(ACT_INVERT, 0, MAX_IDX, 1'b0);
        send_op(ACT_COUNT, 0, 15, 1'b0);
        send_op(ACT_LOAD, MAX_IDX, 0, 1'b1);
        send_op(ACT_LOAD, 0, MAX_IDX, 1'b0);
        send_op(ACT_COUNT, MAX_IDX, MAX_IDX, 1'b0);
        send_op(ACT_COUNT, 0, 0, 1'b0);
        send_op(ACT_COUNT, 9, 5, 1'b0);
        send_op(ACT_SET, 900, 100, 1'b1);
        send_op(ACT_INVERT, 1000, 3, 1'b0);
        send_op(ACT_CLEAR, MAX_IDX, 0, 1'b0);
        send_op(ACT_RSVD5, 0, MAX_IDX, 1'b1);
        send_op(ACT_RSVD6, MAX_IDX, 0, 1'b0);
        send_op(ACT_RSVD7, 0, MAX_IDX, 1'b1);
        send_op(ACT_COUNT, 0, MAX_IDX, 1'b0);
        send_op(ACT_CLEAR, 0, MAX_IDX, 1'b0);
        send_op(ACT_INVERT, 31, 32, 1'b0);
        send_op(ACT_COUNT, 30, 33, 1'b0);
        send_op(ACT_SET, MAX_IDX, MAX_IDX, 1'b0);
        send_op(ACT_COUNT, 1022, MAX_IDX, 1'b0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // stretches of back-to-back traffic on both sides
            if (sent % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (sent == HOLD_AT && !hold_done)
            begin
                hold_done = 1'b1;
                hold_req = 1'b1;
                // a run of counts while the receiver is held fills the unit
                repeat (12)
                begin
                    pick_range(lo, hi);
                    send_op(ACT_COUNT, lo, hi, 1'b0);
                end
            end
            send_random(useful);
            if (useful)
                sent++;
        end
        in_valid = 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("range_bit_set_clear_flip_count_unit_test OK");
        else
            $display("range_bit_set_clear_flip_count_unit_test NOT OK");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/rbscf_pkg.sv
hdl/rbscf_cell.sv
hdl/range_bit_set_clear_flip_count_unit.sv
hdl/rbscf_checker.sv
dv/range_bit_set_clear_flip_count_unit_checker.sv
dv/range_bit_set_clear_flip_count_unit_test.sv
